[rtl/k_way_sorted_list_merge_defines.svh]
// Assertion macros used by the checker file.
`ifndef K_WAY_SORTED_LIST_MERGE_DEFINES_SVH
`define K_WAY_SORTED_LIST_MERGE_DEFINES_SVH

// Check a condition at every edge outside reset.
`define KWM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define KWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check what holds on the cycle after a reset edge.
`define KWM_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

[rtl/kwm_pkg.sv]
package kwm_pkg;

  // Sizing
  localparam int LOG_LISTS  = 3;
  localparam int LIST_DEPTH = 256;
  localparam int NUM_LISTS  = 1 << LOG_LISTS;
  localparam int LIST_W     = LOG_LISTS;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int PTR_W      = $clog2(LIST_DEPTH + 1);
  localparam int CNT_W      = LIST_W;
  localparam int LIDX_W     = LIST_W + 3;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_POPPED    = 2'd0;
  localparam logic [1:0] ST_LOAD_OK   = 2'd1;
  localparam logic [1:0] ST_LOAD_FULL = 2'd2;
  localparam logic [1:0] ST_DONE      = 2'd3;

  typedef struct packed {
    logic        command;
    logic [2:0]  list_id;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] merged_value;
    logic [2:0]  source_list;
  } out_t;

  // Running minimum handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [15:0]       value;
    logic [LIST_W-1:0] idx;
  } best_t;

  // Per-cell commands from the sequencer
  typedef struct packed {
    logic        load;
    logic        rd;
    logic        adv;
    logic        clr;
    logic [15:0] value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

[rtl/k_way_sorted_list_merge.sv]
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_data   (command, list_id, value)
// out      output     out_valid/out_stall out_data (status, merged_value, source_list)
//
// A load is handled in S_IDLE: the selected cell writes its list tail directly.
// A pop reads every head, then the running minimum walks down the cell chain in
// S_SCAN, and S_FINISH writes the result once the output register is free.
// Reset is synchronous and empties every list by clearing the counts; no sweep.
// A result waits in the output register while out_stall is high; the next request
// is taken once no pop is in progress and that register is free or being drained.
module k_way_sorted_list_merge
  import kwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  cell_ctrl_t           ctrl [NUM_LISTS];
  best_t                chain [NUM_LISTS+1];
  logic [NUM_LISTS-1:0] full;
  logic [NUM_LISTS-1:0] sel;
  logic [LIDX_W-1:0]    lid_ext;
  logic [LIST_W+2:0]    src_ext;
  logic                 out_free;
  logic                 accept;
  logic                 load_ok;
  best_t                winner;

  // Cell chain
  assign chain[0] = '0;

  for (genvar k = 0; k < NUM_LISTS; k++) begin : g_cell
    kwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[k]),
      .cell_idx (LIST_W'(k)),
      .best_in  (chain[k]),
      .best_out (chain[k+1]),
      .full     (full[k])
    );
  end

  assign winner   = chain[NUM_LISTS];
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign lid_ext  = {{LIST_W{1'b0}}, in_data.list_id};
  assign src_ext  = {3'b000, winner.idx};

  // Decode the target list of a load
  always_comb begin
    for (int k = 0; k < NUM_LISTS; k++) begin
      sel[k] = (lid_ext == LIDX_W'(k));
    end
  end

  assign load_ok = |(sel & ~full);

  // Sequence loads and pops
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    for (int k = 0; k < NUM_LISTS; k++) begin
      ctrl[k]       = '0;
      ctrl[k].value = in_data.value;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_LOAD) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
              ctrl[k].load = sel[k] && !full[k];
            end
            out_valid_nxt             = 1'b1;
            out_data_nxt.status       = load_ok ? ST_LOAD_OK : ST_LOAD_FULL;
            out_data_nxt.merged_value = '0;
            out_data_nxt.source_list  = '0;
          end else begin
            for (int k = 0; k < NUM_LISTS; k++) begin
              ctrl[k].rd = 1'b1;
            end
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_LISTS - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (winner.found) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
              ctrl[k].adv = (winner.idx == LIST_W'(k));
            end
            out_data_nxt.status       = ST_POPPED;
            out_data_nxt.merged_value = winner.value;
            out_data_nxt.source_list  = src_ext[2:0];
          end else begin
            for (int k = 0; k < NUM_LISTS; k++) begin
              ctrl[k].clr = 1'b1;
            end
            out_data_nxt.status       = ST_DONE;
            out_data_nxt.merged_value = '0;
            out_data_nxt.source_list  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/kwm_cell.sv]
module kwm_cell
  import kwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [LIST_W-1:0] cell_idx,
  input  best_t             best_in,
  output best_t             best_out,
  output logic              full
);

  logic [15:0]      mem [LIST_DEPTH];
  logic [15:0]      head_r;
  logic [PTR_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  best_t            best_r, best_nxt;
  logic             head_ok;

  // Append at the tail, fetch the current head on a pop request
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mem[fill_r[ADDR_W-1:0]] <= ctrl.value;
    end
    if (ctrl.rd) begin
      head_r <= mem[rp_r[ADDR_W-1:0]];
    end
  end

  // Update fill count and read position
  always_comb begin
    fill_nxt = fill_r;
    rp_nxt   = rp_r;
    priority if (ctrl.clr) begin
      fill_nxt = '0;
      rp_nxt   = '0;
    end else begin
      if (ctrl.load) fill_nxt = fill_r + PTR_W'(1);
      if (ctrl.adv)  rp_nxt   = rp_r + PTR_W'(1);
    end
  end

  assign head_ok = (rp_r < fill_r);
  assign full    = (fill_r == PTR_W'(LIST_DEPTH));

  // Take over the minimum only on a strictly smaller head; ties stay upstream
  always_comb begin
    best_nxt = best_in;
    if (head_ok && (!best_in.found || head_r < best_in.value)) begin
      best_nxt.found = 1'b1;
      best_nxt.value = head_r;
      best_nxt.idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      rp_r         <= '0;
      best_r.found <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      rp_r         <= rp_nxt;
      best_r.found <= best_nxt.found;
    end
    best_r.value <= best_nxt.value;
    best_r.idx   <= best_nxt.idx;
  end

  assign best_out = best_r;

endmodule

[rtl/kwm_checker.sv]
`include "k_way_sorted_list_merge_defines.svh"

module kwm_checker
  import kwm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // Hold a stalled result
  `KWM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // Drop any pending result on reset
  `KWM_ASSERT_RST(a_rst_empty, !out_valid, "result present after reset")

  // Zero the value fields of every result that is not a popped value
  `KWM_ASSERT(a_zero_fields, !(out_valid && out_data.status != ST_POPPED) || (out_data.merged_value == 16'd0 && out_data.source_list == 3'd0), "nonzero fields on a non-pop result")

  // Block new requests while a pop scans the lists
  `KWM_ASSERT_NXT(a_pop_busy, in_valid && !in_stall && in_data.command == CMD_POP, in_stall, "request taken during pop")

endmodule

bind k_way_sorted_list_merge kwm_checker u_kwm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
